### rtl/core/lsdce_pkg.sv
// Shared constants and types of the LCD shadow-diff command encoder.
package lsdce_pkg;

    localparam int CELL_COUNT           = 256;
    localparam int CELL_IDX_W           = 8;
    localparam int DEFAULT_VISIBLE_COLS = 40;

    localparam int MAX_BYTES = 7;
    localparam int SEQ_W     = MAX_BYTES * 8;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    localparam int CURSOR_W = 9;
    localparam logic [CURSOR_W-1:0] CURSOR_UNKNOWN = 9'h1FF;
    localparam logic [CURSOR_W-1:0] CURSOR_BARRIER = 9'd127;
    localparam logic [CURSOR_W-1:0] ROW1_START     = 9'd64;
    localparam logic [CURSOR_W-1:0] ROW3_START     = 9'd192;
    localparam int                  CTRL_SPAN      = 128;

    localparam logic [7:0] BSLASH      = 8'h5C;
    localparam logic [7:0] CMD_CTRL_1  = 8'h31;
    localparam logic [7:0] CMD_CTRL_2  = 8'h32;
    localparam logic [7:0] CMD_SET_ADR = 8'h63;
    localparam logic [7:0] ADR_BASE    = 8'h80;
    localparam logic [7:0] ADR_MASK    = 8'h7F;

    // One cell's command bytes, first byte in the lowest bits.
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] bytes;
        logic [CNT_W-1:0] count;
    } byte_load_t;

endpackage

### rtl/core/lsdce_byte_queue.sv
// Output stage that shifts a loaded command sequence out one byte per word.
module lsdce_byte_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lsdce_pkg::byte_load_t  load,
    output logic                   free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // out_byte
    output logic                   m_tlast    // last_byte
);

    logic [lsdce_pkg::SEQ_W-1:0] data_reg;
    logic [lsdce_pkg::SEQ_W-1:0] data_next;
    logic [lsdce_pkg::CNT_W-1:0] cnt_reg;
    logic [lsdce_pkg::CNT_W-1:0] cnt_next;
    logic                        take;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = data_reg[7:0];
    assign m_tlast  = (cnt_reg == lsdce_pkg::CNT_W'(1));
    assign take     = m_tvalid && m_tready;
    // A new sequence may enter as the final byte of the current one leaves.
    assign free     = (cnt_reg == '0) || (m_tlast && m_tready);

    always_comb begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (load.valid) begin
            data_next = load.bytes;
            cnt_next  = load.count;
        end else if (take) begin
            data_next = {8'h00, data_reg[lsdce_pkg::SEQ_W-1:8]};
            cnt_next  = cnt_reg - lsdce_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/core/lcd_shadow_diff_command_encoder.sv
// Top level of the LCD shadow-diff command encoder: shadow memory, cursor and sequencing.
// Path: an accepted cell is registered in stage one; its command bytes are then loaded into
// the output stage, which presents the first of them; a busy output stage holds the cell.
// Throughput: a cell produces one to seven command bytes, or none, and one that produces none
// retires without waiting; the output stage sends one byte per cycle while the receiver is ready.
// Reset: synchronous, active low; the shadow reads as all zeros through per-cell valid bits
// cleared at once, and the tracked cursor becomes unknown. No clearing pass is needed.
module lcd_shadow_diff_command_encoder #(
    parameter int VISIBLE_COLS = lsdce_pkg::DEFAULT_VISIBLE_COLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cell_index [7:0], cell_char [15:8]
    input  logic [1:0]  s_tuser,   // full_refresh [0], frame_start [1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast    // last_byte
);

    localparam int IW = lsdce_pkg::CELL_IDX_W;
    localparam int CW = lsdce_pkg::CURSOR_W;
    localparam logic [6:0]    VIS_LIMIT = 7'(VISIBLE_COLS);
    localparam logic [CW-1:0] WRAP_LOW  = CW'(VISIBLE_COLS);
    localparam logic [CW-1:0] WRAP_HIGH = CW'(lsdce_pkg::CTRL_SPAN + VISIBLE_COLS);

    // Incoming word fields.
    logic [IW-1:0] in_idx;
    logic [7:0]    in_char;
    logic          s_accept;

    assign in_idx   = s_tdata[7:0];
    assign in_char  = s_tdata[15:8];
    assign s_accept = s_tvalid && s_tready;

    // The shadow memory is read-first: each accepted cell writes its new character and
    // reads the old one in the same cycle, so back-to-back cells on one index see each
    // other's writes without any forwarding path.
    logic [7:0]              shadow_mem [lsdce_pkg::CELL_COUNT];
    logic [7:0]              rd_reg;
    logic [lsdce_pkg::CELL_COUNT-1:0] written_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_reg             <= shadow_mem[in_idx];
            shadow_mem[in_idx] <= in_char;
        end
    end

    // Stage one holds the cell while its old character comes out of the memory.
    logic          s1_valid_reg;
    logic [IW-1:0] s1_idx_reg;
    logic [7:0]    s1_char_reg;
    logic          s1_full_reg;
    logic          s1_start_reg;
    logic          s1_written_reg;
    logic          s1_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                written_reg[in_idx] <= 1'b1;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            s1_idx_reg     <= in_idx;
            s1_char_reg    <= in_char;
            s1_full_reg    <= s_tuser[0];
            s1_start_reg   <= s_tuser[1];
            s1_written_reg <= written_reg[in_idx];
        end
    end

    // Decision and command build for the cell in stage one.
    logic [CW-1:0]               cursor_reg;
    logic [CW-1:0]               cursor_next;
    logic [CW-1:0]               cursor_eff;
    logic [CW-1:0]               cursor_adv;
    logic [7:0]                  old_char;
    logic                        send;
    logic                        move;
    logic                        unknown;
    logic                        switch_ctrl;
    logic [7:0]                  adr_byte;
    logic [7:0]                  ctrl_byte;
    logic [lsdce_pkg::SEQ_W-1:0] seq;
    logic [lsdce_pkg::CNT_W-1:0] seq_cnt;
    logic                        q_free;
    lsdce_pkg::byte_load_t       q_load;

    // A cell never written since reset reads as a zero character.
    assign old_char   = s1_written_reg ? rd_reg : 8'h00;
    assign cursor_eff = s1_start_reg ? lsdce_pkg::CURSOR_UNKNOWN : cursor_reg;
    assign send       = (s1_full_reg || (old_char != s1_char_reg))
                        && ({1'b0, s1_idx_reg[5:0]} < VIS_LIMIT);
    assign move       = (cursor_eff != {1'b0, s1_idx_reg});
    assign unknown    = (cursor_eff == lsdce_pkg::CURSOR_UNKNOWN);
    // The cursor past the end (256) counts as the second controller.
    assign switch_ctrl = s1_idx_reg[7] ? (unknown || (cursor_eff[8:7] == 2'b00))
                                       : (unknown || (cursor_eff[8:7] != 2'b00));
    assign adr_byte  = lsdce_pkg::ADR_BASE + (s1_idx_reg & lsdce_pkg::ADR_MASK);
    assign ctrl_byte = s1_idx_reg[7] ? lsdce_pkg::CMD_CTRL_2 : lsdce_pkg::CMD_CTRL_1;

    // The sequence is built from its tail forwards; the first byte ends up lowest.
    always_comb begin
        if (s1_char_reg == lsdce_pkg::BSLASH) begin
            seq     = {40'h0, s1_char_reg, lsdce_pkg::BSLASH};
            seq_cnt = lsdce_pkg::CNT_W'(2);
        end else begin
            seq     = {48'h0, s1_char_reg};
            seq_cnt = lsdce_pkg::CNT_W'(1);
        end
        if (move) begin
            seq     = {seq[31:0], adr_byte, lsdce_pkg::CMD_SET_ADR, lsdce_pkg::BSLASH};
            seq_cnt = seq_cnt + lsdce_pkg::CNT_W'(3);
            if (switch_ctrl) begin
                seq     = {seq[39:0], ctrl_byte, lsdce_pkg::BSLASH};
                seq_cnt = seq_cnt + lsdce_pkg::CNT_W'(2);
            end
        end
    end

    // After a sent cell the cursor sits just past it, held at the controller barrier
    // and wrapped over the invisible columns of each controller's first row.
    always_comb begin
        if ({1'b0, s1_idx_reg} == lsdce_pkg::CURSOR_BARRIER) begin
            cursor_adv = lsdce_pkg::CURSOR_BARRIER;
        end else begin
            cursor_adv = {1'b0, s1_idx_reg} + CW'(1);
        end
        if (cursor_adv == WRAP_LOW) begin
            cursor_adv = lsdce_pkg::ROW1_START;
        end
        if (cursor_adv == WRAP_HIGH) begin
            cursor_adv = lsdce_pkg::ROW3_START;
        end
    end

    // A skipped cell retires at once; a sent one waits for the output stage to free up.
    assign s1_move  = s1_valid_reg && (!send || q_free);
    assign s_tready = !s1_valid_reg || s1_move;

    assign q_load.valid = s1_move && send;
    assign q_load.bytes = seq;
    assign q_load.count = seq_cnt;

    assign cursor_next = send ? cursor_adv : cursor_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= lsdce_pkg::CURSOR_UNKNOWN;
        end else if (s1_move) begin
            cursor_reg <= cursor_next;
        end
    end

    lsdce_byte_queue u_byte_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (q_load),
        .free     (q_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The cursor never rests on an invisible column that the wrap should have skipped.
    a_cursor_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (cursor_reg != WRAP_LOW) && (cursor_reg != WRAP_HIGH))
        else $error("cursor holds an unwrapped position");

    // A cell that sends nothing never holds up the input side.
    a_skip_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !send) |-> s_tready)
        else $error("skipped cell stalled the input");

    // Every accepted cell marks its shadow entry as written.
    a_written_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> written_reg[$past(in_idx)])
        else $error("shadow entry not marked after a write");

endmodule

### sim/testbench.sv
// Self-checking testbench for the LCD shadow-diff command encoder.
module testbench;

    // The display width that the block is built with; the prediction below uses the same value.
    localparam int VIS_COLS    = lsdce_pkg::DEFAULT_VISIBLE_COLS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CELLS = 280;
    // Cycles allowed after the last expected byte for any cell still in flight to show itself.
    localparam int SETTLE_CYCLES = 20;

    // Receiver stall patterns.
    localparam logic [1:0] RX_FREE  = 2'd0;
    localparam logic [1:0] RX_LIGHT = 2'd1;
    localparam logic [1:0] RX_HEAVY = 2'd2;

    // One cell word waiting to be sent; hold_for_drain makes the sender wait until every
    // expected byte has come back before it offers this word.
    typedef struct packed {
        logic [7:0] cell_idx;
        logic [7:0] char_code;
        logic       full_refresh;
        logic       frame_start;
        logic       hold_for_drain;
    } cell_word_t;

    // One byte of the serial command stream as it should appear on the result channel.
    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } cmd_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // cell_index [7:0], cell_char [15:8]
    logic [1:0]  s_tuser  = '0;   // full_refresh [0], frame_start [1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // out_byte
    logic        m_tlast;         // last_byte

    lcd_shadow_diff_command_encoder #(
        .VISIBLE_COLS(VIS_COLS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Cell words still to be offered, and command bytes still to be received.
    cell_word_t pending_cells[$];
    cmd_byte_t  expected_bytes[$];

    // Our own copy of the block's state, advanced as each cell word is accepted.
    logic [7:0]                     shadow_mem [lsdce_pkg::CELL_COUNT];
    logic [lsdce_pkg::CURSOR_W-1:0] lcd_cursor = lsdce_pkg::CURSOR_UNKNOWN;

    // What the stimulus generator believes the shadow will hold once its words are sent;
    // used to pick characters that leave a cell unchanged.
    logic [7:0] planned_char [lsdce_pkg::CELL_COUNT];

    int mismatch_count = 0;
    int cells_taken    = 0;
    int cycle_count    = 0;
    logic word_taken   = 1'b0;

    // Works out the command bytes that one accepted cell word produces and queues them.
    function automatic void encode_cell(input logic [7:0] idx, input logic [7:0] ch,
                                        input logic full, input logic start);
        logic [7:0] prior;
        logic [7:0] seq [lsdce_pkg::MAX_BYTES];
        int         n;
        n = 0;
        if (start) begin
            lcd_cursor = lsdce_pkg::CURSOR_UNKNOWN;
        end
        prior = shadow_mem[idx];
        // The shadow follows every cell, sent or not, visible or not.
        shadow_mem[idx] = ch;
        if ((full || prior != ch) && idx[5:0] < VIS_COLS) begin
            if (lcd_cursor != {1'b0, idx}) begin
                // An unknown cursor always forces a controller switch first.
                if (idx >= lsdce_pkg::CTRL_SPAN) begin
                    if (lcd_cursor == lsdce_pkg::CURSOR_UNKNOWN
                        || lcd_cursor < lsdce_pkg::CTRL_SPAN) begin
                        seq[n] = lsdce_pkg::BSLASH;     n++;
                        seq[n] = lsdce_pkg::CMD_CTRL_2; n++;
                    end
                end else if (lcd_cursor == lsdce_pkg::CURSOR_UNKNOWN
                             || lcd_cursor >= lsdce_pkg::CTRL_SPAN) begin
                    seq[n] = lsdce_pkg::BSLASH;     n++;
                    seq[n] = lsdce_pkg::CMD_CTRL_1; n++;
                end
                seq[n] = lsdce_pkg::BSLASH;      n++;
                seq[n] = lsdce_pkg::CMD_SET_ADR; n++;
                seq[n] = lsdce_pkg::ADR_BASE + (idx & lsdce_pkg::ADR_MASK); n++;
                lcd_cursor = {1'b0, idx};
            end
            // A backslash character goes out doubled so that it is not read as an escape.
            if (ch == lsdce_pkg::BSLASH) begin
                seq[n] = lsdce_pkg::BSLASH; n++;
            end
            seq[n] = ch; n++;
            for (int i = 0; i < n; i++) begin
                expected_bytes.push_back('{value: seq[i], is_last: (i == n - 1)});
            end
            // The cursor sticks at the end of the first controller's range and skips the
            // hidden columns of the first and third rows.
            if (lcd_cursor != lsdce_pkg::CURSOR_BARRIER) begin
                lcd_cursor = lcd_cursor + lsdce_pkg::CURSOR_W'(1);
            end
            if (lcd_cursor == VIS_COLS) begin
                lcd_cursor = lsdce_pkg::ROW1_START;
            end
            if (lcd_cursor == lsdce_pkg::CTRL_SPAN + VIS_COLS) begin
                lcd_cursor = lsdce_pkg::ROW3_START;
            end
        end
    endfunction

    task automatic queue_cell(input logic [7:0] idx, input logic [7:0] ch, input logic full,
                              input logic start, input logic hold);
        pending_cells.push_back('{cell_idx: idx, char_code: ch, full_refresh: full,
                                  frame_start: start, hold_for_drain: hold});
        planned_char[idx] = ch;
    endtask

    // Sender: words change at the falling edge. It works in bursts of random length with
    // random gaps between them, and holds a word until the block has taken it.
    cell_word_t drive_cell;
    int burst_left = 8;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || word_taken)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_cells.size() > 0 &&
                         (!pending_cells[0].hold_for_drain || expected_bytes.size() == 0)) begin
                drive_cell = pending_cells.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {drive_cell.char_code, drive_cell.cell_idx};
                s_tuser  <= {drive_cell.frame_start, drive_cell.full_refresh};
                burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    // About one burst in four runs straight into the next one.
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: its ready follows randomly drawn stall patterns of random length. Once,
    // after a number of cells have gone in, it holds off for a long stretch so that the
    // block backs up and stops taking words.
    logic [1:0] rx_mode      = RX_FREE;
    int         rx_phase_left = 0;
    int         holdoff_left  = 0;
    logic       holdoff_done  = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!holdoff_done && cells_taken >= 60) begin
                holdoff_left = 300;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0) begin
                holdoff_left = holdoff_left - 1;
                m_tready <= 1'b0;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_mode       = 2'($urandom_range(2));
                    rx_phase_left = $urandom_range(16, 80);
                end
                rx_phase_left = rx_phase_left - 1;
                case (rx_mode)
                    RX_FREE: begin
                        m_tready <= 1'b1;
                    end
                    RX_LIGHT: begin
                        m_tready <= ($urandom_range(3) != 0);
                    end
                    RX_HEAVY: begin
                        m_tready <= 1'($urandom_range(1));
                    end
                    default: begin
                        m_tready <= 1'b1;
                    end
                endcase
            end
        end
    end

    // Monitor: at each rising edge an accepted cell word feeds the prediction, and an
    // accepted result word is checked against the oldest expected byte.
    cmd_byte_t want;

    always @(posedge aclk) begin
        if (aresetn) begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                encode_cell(s_tdata[7:0], s_tdata[15:8], s_tuser[0], s_tuser[1]);
                cells_taken = cells_taken + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual out_byte %h last_byte %b",
                             $time, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.value) begin
                        $display("%0t: out_byte: expected %h, actual %h",
                                 $time, want.value, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.is_last) begin
                        $display("%0t: last_byte: expected %b, actual %b",
                                 $time, want.is_last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end else begin
            word_taken <= 1'b0;
        end
    end

    // Guard against a block that stops making progress.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus, reset and the end of the run.
    int   made;
    int   run_len;
    int   pick;
    logic [7:0] run_idx;
    logic [7:0] run_char;
    logic run_full;
    logic run_start;

    initial begin
        for (int i = 0; i < lsdce_pkg::CELL_COUNT; i++) begin
            shadow_mem[i]   = '0;
            planned_char[i] = '0;
        end

        // Directed part. A fresh frame starts with the cursor unknown, so the first cell
        // needs a controller switch and an address.
        queue_cell(8'd0,   8'h41, 1'b0, 1'b1, 1'b0);
        queue_cell(8'd1,   lsdce_pkg::BSLASH, 1'b0, 1'b0, 1'b0);  // cursor already there, doubled
        queue_cell(8'd2,   8'h00, 1'b0, 1'b0, 1'b0);   // unchanged, nothing sent
        queue_cell(8'd3,   8'h00, 1'b1, 1'b0, 1'b0);   // unchanged but refreshed, new address
        queue_cell(8'd39,  8'hFF, 1'b0, 1'b0, 1'b0);   // last visible column
        queue_cell(8'd40,  8'h12, 1'b0, 1'b0, 1'b0);   // hidden column, shadow only
        queue_cell(8'd63,  8'hAA, 1'b1, 1'b0, 1'b0);   // hidden even when refreshed
        queue_cell(8'd64,  8'h80, 1'b0, 1'b0, 1'b0);   // cursor wrapped onto the next row
        queue_cell(8'd127, 8'h7F, 1'b1, 1'b0, 1'b0);
        queue_cell(8'd128, lsdce_pkg::BSLASH, 1'b0, 1'b0, 1'b0);  // second controller, seven bytes
        queue_cell(8'd167, 8'h01, 1'b0, 1'b0, 1'b0);
        queue_cell(8'd192, 8'hFE, 1'b0, 1'b0, 1'b0);   // cursor wrapped onto the fourth row
        queue_cell(8'd255, 8'h33, 1'b0, 1'b0, 1'b0);
        queue_cell(8'd0,   8'h41, 1'b1, 1'b0, 1'b0);   // back to the first controller
        queue_cell(8'd0,   lsdce_pkg::BSLASH, 1'b0, 1'b1, 1'b1);  // new frame after a full drain
        queue_cell(8'd129, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_cell(8'd230, 8'hFF, 1'b1, 1'b0, 1'b0);
        queue_cell(8'd231, 8'h01, 1'b1, 1'b0, 1'b0);
        queue_cell(8'd232, 8'h55, 1'b0, 1'b0, 1'b0);
        queue_cell(8'd100, lsdce_pkg::BSLASH, 1'b0, 1'b0, 1'b0);
        queue_cell(8'd103, 8'h20, 1'b0, 1'b0, 1'b0);
        queue_cell(8'd104, 8'h21, 1'b0, 1'b0, 1'b0);

        // Random part. Most of it is runs of consecutive cells, as a frame update would send
        // them, with a mix of unchanged, backslash and fresh characters; the rest is noise.
        // If the random part opens with a run, that run first waits for the block to drain completely.
        made = 0;
        while (made < RANDOM_CELLS) begin
            pick = $urandom_range(9);
            if (pick < 8) begin
                run_start = ($urandom_range(2) == 0);
                run_idx   = run_start && $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
                run_full  = ($urandom_range(4) == 0);
                run_len   = $urandom_range(1, 70);
                for (int i = 0; i < run_len && made < RANDOM_CELLS; i++) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: run_char = planned_char[run_idx];
                        4:          run_char = lsdce_pkg::BSLASH;
                        default:    run_char = 8'($urandom_range(255));
                    endcase
                    queue_cell(run_idx, run_char, run_full, run_start && i == 0,
                               i == 0 && (made == 0 || $urandom_range(9) == 0));
                    run_idx = run_idx + 8'd1;
                    made++;
                end
            end else begin
                run_len = $urandom_range(1, 6);
                for (int i = 0; i < run_len && made < RANDOM_CELLS; i++) begin
                    queue_cell(8'($urandom_range(255)), 8'($urandom_range(255)),
                               1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
                    made++;
                end
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every word to be taken and every expected byte to arrive, then give the
        // block a little longer in case it still has something to say.
        do begin
            @(negedge aclk);
        end while (pending_cells.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### lcd_shadow_diff_command_encoder.f
rtl/core/lsdce_pkg.sv
rtl/core/lsdce_byte_queue.sv
rtl/core/lcd_shadow_diff_command_encoder.sv
sim/testbench.sv
